// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the airtime calculator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pac_pkg.sv =====
// Shared types, widths and constants of the airtime calculator.
package pac_pkg;

  localparam int PREAMBLE_SYMBOLS = 8;

  localparam int PL_W      = 8;
  localparam int SF_W      = 4;
  localparam int CR_W      = 3;
  localparam int BW_W      = 2;
  localparam int AIR_W     = 24;
  localparam int SYM_W     = 10;
  localparam int DIV_W     = 10;
  localparam int RECIP_W   = 14;
  localparam int RECIP_SH  = 16;
  localparam int PROD_W    = DIV_W + RECIP_W;
  localparam int BLK_W     = 8;
  localparam int SHIFT_W   = 4;
  localparam int QTR_W     = 12;
  localparam int SCALED_W  = QTR_W + 13;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SF_W-1:0] SF_MIN   = 4'd6;
  localparam logic [SF_W-1:0] SF_MAX   = 4'd12;
  localparam logic [SF_W-1:0] SF_DE_LO = 4'd11;
  localparam logic [SF_W-1:0] SF_RESET = 4'd7;
  localparam logic [CR_W-1:0] CR_MIN   = 3'd1;
  localparam logic [CR_W-1:0] CR_MAX   = 3'd4;
  localparam logic [CR_W-1:0] CR_RESET = 3'd1;
  localparam logic [BW_W-1:0] BW_125   = 2'd0;
  localparam logic [BW_W-1:0] BW_250   = 2'd1;
  localparam logic [BW_W-1:0] BW_500   = 2'd2;
  localparam logic [BW_W-1:0] BW_RESET = BW_125;

  localparam logic [REG_IDX_W-1:0] REG_SF = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CR = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BW = 2'd2;

  // Payload numerator in units of 4: (28 + 16) / 4 and 20 / 4.
  localparam logic [DIV_W-1:0] NUM_BIAS = DIV_W'((28 + 16) / 4);
  localparam logic [SF_W-1:0]  IH_BIAS  = SF_W'(20 / 4);
  localparam logic [SYM_W-1:0] PAYLOAD_BASE = SYM_W'(8);
  localparam logic [SHIFT_W-1:0] CR_BASE = SHIFT_W'(4);
  // Preamble length in quarter symbols.
  localparam logic [QTR_W-1:0] PRE_QUARTERS = QTR_W'(4 * PREAMBLE_SYMBOLS + 17);

  typedef struct packed {
    logic [DIV_W-1:0]   dividend;
    logic [RECIP_W-1:0] recip;
    logic [CR_W-1:0]    cr;
    logic [SHIFT_W-1:0] shift;
    logic               de;
    logic               ih;
  } job_t;

  // ceil(2^16 / d) for the divisors 6..12; exact for dividends below 1024.
  function automatic logic [RECIP_W-1:0] recip_lut(input logic [SF_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd6:    r = 14'd10923;
      4'd7:    r = 14'd9363;
      4'd8:    r = 14'd8192;
      4'd9:    r = 14'd7282;
      4'd10:   r = 14'd6554;
      4'd11:   r = 14'd5958;
      4'd12:   r = 14'd5462;
      default: r = 14'd8192;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/pac_front.sv =====
// Front end: clamps configuration, classifies the request and forms the divide job.
module pac_front (
  input  logic                        in_valid,
  input  logic [pac_pkg::PL_W-1:0]    in_payload_length,
  input  logic [pac_pkg::SF_W-1:0]    cfg_sf,
  input  logic [pac_pkg::CR_W-1:0]    cfg_cr,
  input  logic [pac_pkg::BW_W-1:0]    cfg_bw,
  input  logic                        q_full,
  output logic                        in_stall,
  output logic                        push,
  output pac_pkg::job_t               job
);
  import pac_pkg::*;

  logic [SF_W-1:0]  sf_s;
  logic [CR_W-1:0]  cr_s;
  logic [BW_W-1:0]  bw_s;
  logic             de;
  logic             ih;
  logic [SF_W-1:0]  d;
  logic [SF_W-1:0]  b;
  logic [DIV_W-1:0] a;
  logic             num_pos;

  always_comb begin
    if (cfg_sf < SF_MIN) sf_s = SF_MIN;
    else if (cfg_sf > SF_MAX) sf_s = SF_MAX;
    else sf_s = cfg_sf;

    if (cfg_cr < CR_MIN) cr_s = CR_MIN;
    else if (cfg_cr > CR_MAX) cr_s = CR_MAX;
    else cr_s = cfg_cr;

    bw_s = (cfg_bw > BW_500) ? BW_500 : cfg_bw;
  end

  assign de = (bw_s == BW_125) && (sf_s >= SF_DE_LO);
  assign ih = (sf_s == SF_MIN);
  assign d  = sf_s - {{(SF_W-2){1'b0}}, de, 1'b0};
  assign b  = sf_s + (ih ? IH_BIAS : '0);
  assign a  = {1'b0, in_payload_length, 1'b0} + NUM_BIAS;
  assign num_pos = a > {{(DIV_W-SF_W){1'b0}}, b};

  always_comb begin
    job.dividend = num_pos
                 ? a + {{(DIV_W-SF_W){1'b0}}, d} - DIV_W'(1) - {{(DIV_W-SF_W){1'b0}}, b}
                 : '0;
    job.recip    = recip_lut(d);
    job.cr       = cr_s;
    job.shift    = sf_s + SHIFT_W'(1) - {{(SHIFT_W-BW_W){1'b0}}, bw_s};
    job.de       = de;
    job.ih       = ih;
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

// ===== rtl/pac_queue.sv =====
// Two-entry request queue between the front end and the arithmetic back end.
`include "assert_macros.svh"

module pac_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pac_pkg::job_t job_in,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output pac_pkg::job_t job_out
);
  import pac_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign job_out = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + QCNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= job_in;
  end

  `ASSERT_ALWAYS(a_q_count_bound, clk, rst_n, count_r <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  `ASSERT_NEXT(a_q_push_visible, clk, rst_n, do_push && !do_pop, valid, "pushed request not visible")

endmodule

// ===== rtl/pac_back.sv =====
// Back end: reciprocal divide, symbol count and airtime scaling in three stages.
`include "assert_macros.svh"

module pac_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  pac_pkg::job_t                 q_job,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pac_pkg::AIR_W-1:0]     out_airtime_us,
  output logic [pac_pkg::SYM_W-1:0]     out_payload_symbols,
  output logic                          out_low_rate_opt,
  output logic                          out_implicit_header
);
  import pac_pkg::*;

  logic s1_ready, s2_ready, s3_ready;

  // Stage 1: ceiling quotient via reciprocal multiply.
  logic                s1_valid_r, s1_valid_nxt;
  logic [BLK_W-1:0]    s1_blocks_r;
  logic [CR_W-1:0]     s1_cr_r;
  logic [SHIFT_W-1:0]  s1_shift_r;
  logic                s1_de_r, s1_ih_r;
  logic [PROD_W-1:0]   prod;
  logic [BLK_W-1:0]    s1_blocks_nxt;

  // Stage 2: payload symbol count.
  logic                s2_valid_r, s2_valid_nxt;
  logic [SYM_W-1:0]    s2_sym_r, s2_sym_nxt;
  logic [SHIFT_W-1:0]  s2_shift_r;
  logic                s2_de_r, s2_ih_r;
  logic [SHIFT_W-1:0]  cr_mult;
  logic [BLK_W+SHIFT_W-1:0] blk_prod;

  // Stage 3: output register.
  logic                s3_valid_r, s3_valid_nxt;
  logic [AIR_W-1:0]    s3_air_r, s3_air_nxt;
  logic [SYM_W-1:0]    s3_sym_r;
  logic                s3_de_r, s3_ih_r;
  logic [QTR_W-1:0]    quarters;
  logic [SCALED_W-1:0] scaled;

  assign s3_ready = !s3_valid_r || !out_stall;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign pop      = q_valid && s1_ready;

  assign prod          = q_job.dividend * q_job.recip;
  assign s1_blocks_nxt = prod[RECIP_SH +: BLK_W];

  assign cr_mult    = {{(SHIFT_W-CR_W){1'b0}}, s1_cr_r} + CR_BASE;
  assign blk_prod   = s1_blocks_r * cr_mult;
  assign s2_sym_nxt = SYM_W'(blk_prod) + PAYLOAD_BASE;

  assign quarters   = PRE_QUARTERS + {s2_sym_r, 2'b00};
  assign scaled     = SCALED_W'(quarters) << s2_shift_r;
  assign s3_air_nxt = (scaled[SCALED_W-1:AIR_W] != '0) ? {AIR_W{1'b1}} : scaled[AIR_W-1:0];

  assign s1_valid_nxt = s1_ready ? q_valid : s1_valid_r;
  assign s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;
  assign s3_valid_nxt = s3_ready ? s2_valid_r : s3_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && q_valid) begin
      s1_blocks_r <= s1_blocks_nxt;
      s1_cr_r     <= q_job.cr;
      s1_shift_r  <= q_job.shift;
      s1_de_r     <= q_job.de;
      s1_ih_r     <= q_job.ih;
    end
    if (s2_ready && s1_valid_r) begin
      s2_sym_r   <= s2_sym_nxt;
      s2_shift_r <= s1_shift_r;
      s2_de_r    <= s1_de_r;
      s2_ih_r    <= s1_ih_r;
    end
    if (s3_ready && s2_valid_r) begin
      s3_air_r <= s3_air_nxt;
      s3_sym_r <= s2_sym_r;
      s3_de_r  <= s2_de_r;
      s3_ih_r  <= s2_ih_r;
    end
  end

  assign out_valid           = s3_valid_r;
  assign out_airtime_us      = s3_air_r;
  assign out_payload_symbols = s3_sym_r;
  assign out_low_rate_opt    = s3_de_r;
  assign out_implicit_header = s3_ih_r;

  `ASSERT_ALWAYS(a_sym_floor, clk, rst_n, !out_valid || out_payload_symbols >= PAYLOAD_BASE, "symbol count below floor")
  `ASSERT_ALWAYS(a_ih_no_de, clk, rst_n, !(out_valid && out_implicit_header && out_low_rate_opt), "implicit header with low rate opt")

endmodule

// ===== rtl/packet_airtime_calc.sv =====
// Top level of the chirp-spread packet airtime calculator.
// Takes one payload length per cycle while in_stall is low and returns the time on air
// in whole microseconds, the payload symbol count and the low-rate-optimisation and
// implicit-header flags. A request is registered in the two-entry request queue; the
// reciprocal multiply on the queue head is registered into the first back-end stage,
// then the symbol-count multiply and the scaling stage follow. Throughput is one request
// per cycle while out_stall is low; under output stall the three back-end stages and the
// queue absorb requests before in_stall rises.
// Registers (APB, 4-byte spacing): 0 spreading factor, 1 coding rate, 2 bandwidth select.
module packet_airtime_calc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pac_pkg::ADDR_W-1:0]    paddr,
  input  logic [pac_pkg::DATA_W-1:0]    pwdata,
  output logic [pac_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pac_pkg::PL_W-1:0]      in_payload_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pac_pkg::AIR_W-1:0]     out_airtime_us,
  output logic [pac_pkg::SYM_W-1:0]     out_payload_symbols,
  output logic                          out_low_rate_opt,
  output logic                          out_implicit_header
);
  import pac_pkg::*;

  logic [SF_W-1:0]      sf_r, sf_nxt;
  logic [CR_W-1:0]      cr_r, cr_nxt;
  logic [BW_W-1:0]      bw_r, bw_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  logic push, q_full, q_valid, pop;
  job_t front_job, q_job;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    sf_nxt = sf_r;
    cr_nxt = cr_r;
    bw_nxt = bw_r;
    if (wr_en) begin
      case (reg_idx)
        REG_SF:  sf_nxt = pwdata[SF_W-1:0];
        REG_CR:  cr_nxt = pwdata[CR_W-1:0];
        REG_BW:  bw_nxt = pwdata[BW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r <= SF_RESET;
      cr_r <= CR_RESET;
      bw_r <= BW_RESET;
    end else begin
      sf_r <= sf_nxt;
      cr_r <= cr_nxt;
      bw_r <= bw_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SF:  prdata = {{(DATA_W-SF_W){1'b0}}, sf_r};
      REG_CR:  prdata = {{(DATA_W-CR_W){1'b0}}, cr_r};
      REG_BW:  prdata = {{(DATA_W-BW_W){1'b0}}, bw_r};
      default: prdata = '0;
    endcase
  end

  pac_front u_front (
    .in_valid          (in_valid),
    .in_payload_length (in_payload_length),
    .cfg_sf            (sf_r),
    .cfg_cr            (cr_r),
    .cfg_bw            (bw_r),
    .q_full            (q_full),
    .in_stall          (in_stall),
    .push              (push),
    .job               (front_job)
  );

  pac_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (front_job),
    .full    (q_full),
    .pop     (pop),
    .valid   (q_valid),
    .job_out (q_job)
  );

  pac_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_job               (q_job),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_airtime_us      (out_airtime_us),
    .out_payload_symbols (out_payload_symbols),
    .out_low_rate_opt    (out_low_rate_opt),
    .out_implicit_header (out_implicit_header)
  );

endmodule
